// ----- hw/rtl/mtu_pkg.sv -----
// mtu_pkg: shared types, codes and constants for the 4x4 matrix transform unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package mtu_pkg;

	// Fixed field widths of the transaction payloads
	localparam int unsigned DIM       = 4;
	localparam int unsigned NELEM     = DIM * DIM;
	localparam int unsigned IDX_W     = $clog2(NELEM);
	localparam int unsigned K_W       = $clog2(DIM);
	localparam int unsigned ROW_W     = $clog2(DIM);
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned TOL_W     = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

	// Defaults for the top-level parameters
	localparam int unsigned WORD_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Command codes; 6 and 7 are ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A    = 3'd0,
		CMD_LOAD_B    = 3'd1,
		CMD_TRANSFORM = 3'd2,
		CMD_MULTIPLY  = 3'd3,
		CMD_TRANSPOSE = 3'd4,
		CMD_COMPARE   = 3'd5
	} cmd_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_PIPE,
		ST_EMIT,
		ST_TRN,
		ST_CMP
	} state_t;

	// Source of the result written to the output register
	typedef enum logic [1:0] {
		SRC_MAC,
		SRC_TRN,
		SRC_CMP
	} src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic             load_a;
		logic             load_b;
		logic             cap;
		logic             step;
		logic             first;
		logic             mul_sel;
		logic             wa_shift;
		logic             wb_rot;
		logic             wb_shift;
		logic             vq_shift;
		logic             cmp_step;
		logic             cmp_first;
		logic             emit;
		src_t             src;
		logic [ROW_W-1:0] row;
		logic             last;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mtu_ifs.sv -----
// Channel interfaces of the matrix transform unit: request and response.
// Valid/ready handshake; payload widths come from mtu_pkg.
`default_nettype none

interface mtu_req_if import mtu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic [IDX_W-1:0]         elem_index;
	logic signed [DATA_W-1:0] elem_value;
	logic signed [DATA_W-1:0] vec_x;
	logic signed [DATA_W-1:0] vec_y;
	logic signed [DATA_W-1:0] vec_z;
	logic signed [DATA_W-1:0] vec_w;

	modport source (
		output valid, cmd, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
		input  ready
	);
	modport sink (
		input  valid, cmd, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
		output ready
	);
endinterface

interface mtu_rsp_if import mtu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] res_0;
	logic signed [DATA_W-1:0] res_1;
	logic signed [DATA_W-1:0] res_2;
	logic signed [DATA_W-1:0] res_3;
	logic [ROW_W-1:0]         row_number;
	logic                     match;
	logic                     overflow;
	logic                     last;

	modport source (
		output valid, res_0, res_1, res_2, res_3, row_number, match, overflow, last,
		input  ready
	);
	modport sink (
		input  valid, res_0, res_1, res_2, res_3, row_number, match, overflow, last,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/mtu_ctrl.sv -----
// mtu_ctrl: command sequencer of the matrix transform unit.
// Depends on mtu_pkg; drives the datapath through a ctrl_t command bundle.
`default_nettype none

module mtu_ctrl import mtu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	output logic             in_ready,
	input  logic             out_free,
	output ctrl_t            ctrl
);

	state_t           state_q, state_d;
	cmd_t             mode_q;
	logic [IDX_W-1:0] cnt_q;
	logic [ROW_W-1:0] row_q;
	logic             is_mul;
	logic             emit_last;

	assign is_mul    = (mode_q == CMD_MULTIPLY);
	assign emit_last = !is_mul || (row_q == ROW_W'(DIM - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_TRANSFORM, CMD_MULTIPLY: state_d = ST_MAC;
						CMD_TRANSPOSE:               state_d = ST_TRN;
						CMD_COMPARE:                 state_d = ST_CMP;
						default:                     state_d = ST_IDLE;
					endcase
				end
			end
			ST_MAC: begin
				if (cnt_q[K_W-1:0] == K_W'(DIM - 1))
					state_d = ST_PIPE;
			end
			ST_PIPE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free)
					state_d = emit_last ? ST_IDLE : ST_MAC;
			end
			ST_TRN: begin
				if (out_free && row_q == ROW_W'(DIM - 1))
					state_d = ST_IDLE;
			end
			ST_CMP: begin
				if (cnt_q == IDX_W'(NELEM - 1))
					state_d = ST_EMIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		ctrl     = '0;
		ctrl.src = SRC_MAC;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_cmd)
						CMD_LOAD_A: ctrl.load_a = 1'b1;
						CMD_LOAD_B: ctrl.load_b = 1'b1;
						CMD_TRANSFORM, CMD_MULTIPLY, CMD_TRANSPOSE, CMD_COMPARE:
							ctrl.cap = 1'b1;
						default: ;
					endcase
				end
			end
			ST_MAC: begin
				ctrl.step     = 1'b1;
				ctrl.first    = (cnt_q[K_W-1:0] == '0);
				ctrl.mul_sel  = is_mul;
				ctrl.wa_shift = 1'b1;
				ctrl.wb_rot   = is_mul;
				ctrl.vq_shift = !is_mul;
			end
			ST_PIPE: ;
			ST_EMIT: begin
				ctrl.src  = (mode_q == CMD_COMPARE) ? SRC_CMP : SRC_MAC;
				ctrl.row  = row_q;
				ctrl.last = emit_last;
				ctrl.emit = out_free;
			end
			ST_TRN: begin
				ctrl.src      = SRC_TRN;
				ctrl.row      = row_q;
				ctrl.last     = (row_q == ROW_W'(DIM - 1));
				ctrl.emit     = out_free;
				ctrl.wa_shift = out_free;
			end
			ST_CMP: begin
				ctrl.cmp_step  = 1'b1;
				ctrl.cmp_first = (cnt_q == '0);
				ctrl.wa_shift  = 1'b1;
				ctrl.wb_shift  = 1'b1;
			end
			default: ;
		endcase
	end

	// State, step counter, row counter and latched command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= CMD_LOAD_A;
			cnt_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					row_q <= '0;
					if (in_valid && ctrl.cap)
						mode_q <= cmd_t'(in_cmd);
				end
				ST_MAC, ST_CMP: cnt_q <= cnt_q + IDX_W'(1);
				ST_EMIT: begin
					if (out_free) begin
						cnt_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_TRN: begin
					if (out_free)
						row_q <= row_q + ROW_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Sequencing checks
	a_mac_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> (mode_q == CMD_TRANSFORM || mode_q == CMD_MULTIPLY))
		else $error("MAC steps issued for a command without products");

	a_single_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !is_mul |-> row_q == '0)
		else $error("single-result command emitted with non-zero row");

	a_pipe_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PIPE |=> state_q == ST_EMIT && $past(mode_q) == mode_q)
		else $error("drain cycle not followed by emit");

	a_cmp_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && in_valid && in_cmd == CMD_COMPARE
		|=> state_q == ST_CMP && cnt_q == '0)
		else $error("compare sweep did not start at element zero");

endmodule

`default_nettype wire

// ----- hw/rtl/mtu_datapath.sv -----
// mtu_datapath: matrix storage, working copies, four multiply-accumulate lanes,
// compare unit and output register of the matrix transform unit.
// Depends on mtu_pkg and mtu_rsp_if; sequenced by mtu_ctrl.
`default_nettype none

module mtu_datapath import mtu_pkg::*; #(
	parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl,
	output logic                     out_free,
	input  logic                     cfg_we,
	input  logic [TOL_W-1:0]         cfg_wdata,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] elem_value,
	input  logic signed [DATA_W-1:0] vec_x,
	input  logic signed [DATA_W-1:0] vec_y,
	input  logic signed [DATA_W-1:0] vec_z,
	input  logic signed [DATA_W-1:0] vec_w,
	mtu_rsp_if.source                rsp
);

	localparam int unsigned EFF_W  = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
	localparam int unsigned PROD_W = EFF_W + DATA_W;
	localparam int unsigned ACC_W  = PROD_W + 2;
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W - EFF_W + 1){1'b0}}, {(EFF_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [EFF_W-1:0]  mat_a_q [NELEM];
	logic signed [EFF_W-1:0]  mat_b_q [NELEM];
	logic signed [EFF_W-1:0]  wa_q    [NELEM];
	logic signed [EFF_W-1:0]  wb_q    [NELEM];
	logic signed [DATA_W-1:0] vq_q    [DIM];
	logic [TOL_W-1:0]         tolerance_q;

	logic signed [EFF_W-1:0]  mul_x   [DIM];
	logic signed [DATA_W-1:0] mul_y   [DIM];
	logic signed [PROD_W-1:0] prod_s1 [DIM];
	logic                     step_s1;
	logic                     first_s1;
	logic signed [ACC_W-1:0]  term    [DIM];
	logic signed [ACC_W-1:0]  acc_q   [DIM];
	logic signed [EFF_W-1:0]  sat_val [DIM];
	logic [DIM-1:0]           sat_ovf;

	logic signed [EFF_W:0]    cmp_diff;
	logic [EFF_W:0]           cmp_mag;
	logic                     cmp_ok;
	logic                     eq_q;

	logic signed [DATA_W-1:0] res_d [DIM];
	logic signed [DATA_W-1:0] res_q [DIM];
	logic [ROW_W-1:0]         row_q;
	logic                     match_q;
	logic                     ovf_q;
	logic                     last_q;
	logic                     out_valid_q;

	// Tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (cfg_we) begin
			tolerance_q <= cfg_wdata;
		end
	end

	// Stored matrices A and B, written one element per load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NELEM; i++) begin
				mat_a_q[i] <= '0;
				mat_b_q[i] <= '0;
			end
		end else begin
			if (ctrl.load_a)
				mat_a_q[elem_index] <= elem_value[EFF_W-1:0];
			if (ctrl.load_b)
				mat_b_q[elem_index] <= elem_value[EFF_W-1:0];
		end
	end

	// Working copies: captured at command start, then shifted so every lane
	// reads a fixed position
	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			wa_q    <= mat_a_q;
			wb_q    <= mat_b_q;
			vq_q[0] <= vec_x;
			vq_q[1] <= vec_y;
			vq_q[2] <= vec_z;
			vq_q[3] <= vec_w;
		end else begin
			if (ctrl.wa_shift) begin
				for (int i = 0; i < NELEM; i++)
					wa_q[i] <= wa_q[(i + 1) % NELEM];
			end
			if (ctrl.wb_rot) begin
				for (int i = 0; i < NELEM; i++)
					wb_q[i] <= wb_q[(i + DIM) % NELEM];
			end else if (ctrl.wb_shift) begin
				for (int i = 0; i < NELEM; i++)
					wb_q[i] <= wb_q[(i + 1) % NELEM];
			end
			if (ctrl.vq_shift) begin
				for (int i = 0; i < DIM; i++)
					vq_q[i] <= vq_q[(i + 1) % DIM];
			end
		end
	end

	// Lane operands: multiply uses A[r][k] against row k of B,
	// transform uses column k of A against vector component k
	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			mul_x[c] = ctrl.mul_sel ? wa_q[0] : wa_q[c * DIM];
			mul_y[c] = ctrl.mul_sel ? DATA_W'(wb_q[c]) : vq_q[0];
		end
	end

	// Product stage
	always_ff @(posedge clk) begin
		for (int c = 0; c < DIM; c++)
			prod_s1[c] <= mul_x[c] * mul_y[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1  <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			step_s1  <= ctrl.step;
			first_s1 <= ctrl.first;
		end
	end

	// Accumulate stage: floor-shifted products summed exactly
	always_comb begin
		for (int c = 0; c < DIM; c++)
			term[c] = ACC_W'(prod_s1[c] >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (step_s1) begin
			for (int c = 0; c < DIM; c++)
				acc_q[c] <= first_s1 ? term[c] : acc_q[c] + term[c];
		end
	end

	// Saturation to the element width
	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			if (acc_q[c] > SAT_HI) begin
				sat_val[c] = SAT_HI[EFF_W-1:0];
				sat_ovf[c] = 1'b1;
			end else if (acc_q[c] < SAT_LO) begin
				sat_val[c] = SAT_LO[EFF_W-1:0];
				sat_ovf[c] = 1'b1;
			end else begin
				sat_val[c] = acc_q[c][EFF_W-1:0];
				sat_ovf[c] = 1'b0;
			end
		end
	end

	// Compare unit: one element pair per cycle
	assign cmp_diff = (EFF_W + 1)'(wa_q[0]) - (EFF_W + 1)'(wb_q[0]);
	assign cmp_mag  = cmp_diff[EFF_W] ? (EFF_W + 1)'(-cmp_diff) : (EFF_W + 1)'(cmp_diff);
	assign cmp_ok   = (cmp_mag <= {{(EFF_W + 1 - TOL_W){1'b0}}, tolerance_q});

	always_ff @(posedge clk) begin
		if (ctrl.cmp_step)
			eq_q <= (ctrl.cmp_first || eq_q) && cmp_ok;
	end

	// Result selection
	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			case (ctrl.src)
				SRC_MAC: res_d[c] = DATA_W'(sat_val[c]);
				SRC_TRN: res_d[c] = DATA_W'(wa_q[c * DIM]);
				SRC_CMP: res_d[c] = '0;
				default: res_d[c] = '0;
			endcase
		end
	end

	// Output register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			res_q   <= res_d;
			row_q   <= ctrl.row;
			match_q <= (ctrl.src == SRC_CMP) && eq_q;
			ovf_q   <= (ctrl.src == SRC_MAC) && (|sat_ovf);
			last_q  <= ctrl.last;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.res_0      = res_q[0];
	assign rsp.res_1      = res_q[1];
	assign rsp.res_2      = res_q[2];
	assign rsp.res_3      = res_q[3];
	assign rsp.row_number = row_q;
	assign rsp.match      = match_q;
	assign rsp.overflow   = ovf_q;
	assign rsp.last       = last_q;

	// Datapath checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (!out_valid_q || rsp.ready))
		else $error("result written over an untaken transaction");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !step_s1)
		else $error("result emitted while a product is still in flight");

	a_cmp_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmp_step |-> !ctrl.step && !step_s1 && !ctrl.wb_rot)
		else $error("compare sweep overlaps multiply-accumulate");

endmodule

`default_nettype wire

// ----- hw/rtl/matrix4_transform_unit.sv -----
// matrix4_transform_unit: top level of the 4x4 Q16.16 matrix transform unit.
// Depends on mtu_pkg, mtu_req_if/mtu_rsp_if, mtu_ctrl and mtu_datapath.
//
// The unit holds matrices A and B and works on one request transaction at a
// time; a new request is taken once the previous command has issued all of
// its results, while the last result may still wait in the output register.
// Compute commands run through four multiply-accumulate lanes, one 32x32
// multiplier each, with one product stage and one accumulate stage: a
// transform runs four lane steps, a drain state and an emit, a multiply
// the same sequence once per result row, four rows. A transpose emits one
// row per cycle while the output register is free. A compare walks the 16
// element pairs through one subtract-and-compare unit.
// Every emit waits while the output register holds an untaken transaction.
`default_nettype none

module matrix4_transform_unit import mtu_pkg::*; #(
	parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	mtu_req_if.sink          req,
	mtu_rsp_if.source        rsp
);

	ctrl_t ctrl;
	logic  out_free;
	logic  in_ready;

	assign req.ready = in_ready;

	mtu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (in_ready),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	mtu_datapath #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.out_free   (out_free),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.elem_index (req.elem_index),
		.elem_value (req.elem_value),
		.vec_x      (req.vec_x),
		.vec_y      (req.vec_y),
		.vec_z      (req.vec_z),
		.vec_w      (req.vec_w),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire
